// ----- hw/rtl/chd_pkg.sv -----
// Shared types, constants and helpers for the ciphered header deframer.
`timescale 1ns / 1ps

package chd_pkg;

  localparam int KEY_BYTES   = 20;
  localparam int HDR_BYTES   = 4;
  localparam int NUM_KEEP_OPS = 15;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LOW     = 2'd0;
  localparam logic [1:0] REG_KEY_MID     = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH    = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  // opcodes whose frames are kept
  localparam logic [15:0] KEEP_OPS [NUM_KEEP_OPS] = '{
    16'h003B, 16'h0051, 16'h0067, 16'h0068, 16'h008A,
    16'h0092, 16'h0096, 16'h0099, 16'h009B, 16'h01CB,
    16'h01EE, 16'h0236, 16'h02A9, 16'h03EF, 16'h03F1
  };

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       byte_kind;
    logic [15:0] frame_opcode;
    logic [15:0] frame_length;
    logic        frame_end;
    logic        keep_en;     // keep may be set if the opcode matches
    logic        overflow;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic op_kept(input logic [15:0] op);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_KEEP_OPS; i++) begin
      if (op == KEEP_OPS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- hw/rtl/chd_front.sv -----
// Front end: config registers, header decipher, frame tracking, beat classification.
`timescale 1ns / 1ps

module chd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  output chd_pkg::item_t     item
);
  import chd_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_mid;
  logic [31:0] key_high;
  logic [15:0] max_payload;

  logic [4:0]  key_index;
  logic [7:0]  last_cipher;
  logic [1:0]  header_count;
  logic [23:0] header_store;
  logic [15:0] payload_left;
  logic [15:0] cur_opcode;
  logic [15:0] cur_length;
  logic        halted;

  logic [7:0]  key_b [KEY_BYTES];
  logic [7:0]  plain;
  logic [15:0] raw_size;
  logic [15:0] new_length;
  logic [15:0] new_opcode;
  logic        bad_size;
  logic        in_payload;
  logic        hdr_last;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_b[i]     = key_low[8*i +: 8];
      key_b[8 + i] = key_mid[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      key_b[16 + i] = key_high[8*i +: 8];
    end
  end

  assign plain      = (in_byte - last_cipher) ^ key_b[key_index];
  assign raw_size   = {header_store[7:0], header_store[15:8]};
  assign new_length = raw_size - 16'd2;
  assign new_opcode = {plain, header_store[23:16]};
  assign bad_size   = (raw_size[15:1] == 15'd0) || (new_length > max_payload);
  assign in_payload = (payload_left != 16'd0);
  assign hdr_last   = (header_count == 2'(HDR_BYTES - 1));

  always_comb begin
    item = '0;
    if (halted) begin
      item.byte_kind    = KIND_DROP;
      item.frame_opcode = cur_opcode;
      item.frame_length = cur_length;
      item.overflow     = 1'b1;
    end else if (in_payload) begin
      item.out_byte     = in_byte;
      item.byte_kind    = KIND_PAYLOAD;
      item.frame_opcode = cur_opcode;
      item.frame_length = cur_length;
      item.frame_end    = (payload_left == 16'd1);
      item.keep_en      = 1'b1;
    end else begin
      item.out_byte  = plain;
      item.byte_kind = KIND_HEADER;
      if (hdr_last) begin
        item.frame_opcode = new_opcode;
        item.frame_length = new_length;
        item.overflow     = bad_size;
        item.keep_en      = !bad_size;
        item.frame_end    = !bad_size && (new_length == 16'd0);
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_mid     <= '0;
      key_high    <= '0;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_LOW:     key_low     <= cfg_data;
        REG_KEY_MID:     key_mid     <= cfg_data;
        REG_KEY_HIGH:    key_high    <= cfg_data[31:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_index    <= '0;
      last_cipher  <= '0;
      header_count <= '0;
      payload_left <= '0;
      cur_opcode   <= '0;
      cur_length   <= '0;
      halted       <= 1'b0;
    end else if (accept && !halted) begin
      if (in_payload) begin
        payload_left <= payload_left - 16'd1;
      end else begin
        last_cipher <= in_byte;
        key_index   <= (key_index == 5'(KEY_BYTES - 1)) ? 5'd0 : key_index + 5'd1;
        if (hdr_last) begin
          header_count <= '0;
          cur_opcode   <= new_opcode;
          cur_length   <= new_length;
          if (bad_size) halted <= 1'b1;
          else payload_left <= new_length;
        end else begin
          header_count <= header_count + 2'd1;
        end
      end
    end
  end

  // header bytes 0..2 are always rewritten before the fourth byte reads them
  always_ff @(posedge clk) begin
    if (accept && !halted && !in_payload && !hdr_last) begin
      header_store[8*header_count +: 8] <= plain;
    end
  end

endmodule

// ----- hw/rtl/chd_fifo.sv -----
// Two-entry queue of classified beats between front and back.
`timescale 1ns / 1ps

module chd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  chd_pkg::item_t      push_item,
  input  logic                pop,
  output chd_pkg::item_t      head,
  output chd_pkg::fifo_stat_t stat
);
  import chd_pkg::*;

  item_t      mem [FIFO_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == 2'(FIFO_DEPTH));
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ----- hw/rtl/chd_back.sv -----
// Back end: opcode keep lookup and the output register.
`timescale 1ns / 1ps

module chd_back (
  input  logic                clk,
  input  logic                rst,
  input  chd_pkg::item_t      head,
  input  chd_pkg::fifo_stat_t stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import chd_pkg::*;

  logic keep;

  assign pop  = !stat.empty && (!out_tvalid || out_tready);
  assign keep = head.keep_en && op_kept(head.frame_opcode);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (pop) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tdata <= {6'd0, head.overflow, keep, head.frame_length,
                    head.frame_opcode, head.out_byte};
      out_tuser <= head.byte_kind;
      out_tlast <= head.frame_end;
    end
  end

endmodule

// ----- hw/rtl/ciphered_header_deframer.sv -----
// Ciphered header deframer: takes one received byte per cycle while the
// front-to-back queue is not full, deciphers the four header bytes of each
// frame by subtracting the previous cipher byte and XORing with a 20-byte
// key, passes the payload through and tags every byte with its kind and
// the frame's opcode and length. A size field below 2 or a payload length
// (size minus 2) above max_payload sets a sticky overflow and every later
// byte comes out as a dropped beat until reset. Throughput is one byte per
// clock while the output is not stalled; a byte is written into the
// front-to-back queue when it is taken and moves from there to the output
// register when the output is free. The combinational decipher and the
// registered header state update in the front set that rate. Config writes
// are expected only while no beat is in flight.
`timescale 1ns / 1ps

module ciphered_header_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte, [23:8] frame_opcode, [39:24] frame_length,
  // [40] keep, [41] overflow, [47:42] zero
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] byte_kind
  output logic        out_tlast   // frame_end
);
  import chd_pkg::*;

  item_t      push_item;
  item_t      head;
  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;

  assign in_tready = !fifo_stat.full;
  assign push      = in_tvalid && in_tready;

  chd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push),
    .in_byte   (in_tdata),
    .item      (push_item)
  );

  chd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  chd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (fifo_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_fifo_stat: assert property (@(posedge clk) disable iff (rst)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue reports full and empty together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_stat.empty)
    else $error("back popped an empty queue");

  a_drop_beat: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.byte_kind == KIND_DROP) |->
      (push_item.overflow && push_item.out_byte == 8'd0 && !push_item.keep_en))
    else $error("dropped beat without overflow or with data");

  a_end_ok: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.frame_end) |-> !push_item.overflow)
    else $error("frame end on an overflowed beat");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the ciphered header deframer.
`timescale 1ns / 1ps

module tb;
  import chd_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic [15:0] opcode;
    logic [15:0] length;
    logic        frame_end;
    logic        keep;
    logic        overflow;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  ciphered_header_deframer dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] kept_list [0:14] = '{
    16'h003B, 16'h0051, 16'h0067, 16'h0068, 16'h008A,
    16'h0092, 16'h0096, 16'h0099, 16'h009B, 16'h01CB,
    16'h01EE, 16'h0236, 16'h02A9, 16'h03EF, 16'h03F1
  };

  // register mirror
  logic [63:0] key_lo = '0, key_md = '0;
  logic [31:0] key_hi = '0;
  logic [15:0] max_len = MAX_PAYLOAD_RST;

  // deframer state as predicted
  int          hdr_ki = 0;
  logic [7:0]  last_cipher = '0;
  int          hdr_count = 0;
  logic [23:0] hdr_plain = '0;
  logic [15:0] payload_left = '0, cur_opcode = '0, cur_length = '0;
  logic        halted = 1'b0;

  // encoder side of the stimulus
  int         enc_ki = 0;
  logic [7:0] enc_lc = '0;

  logic [7:0] rx_bytes [$];
  deframed_t  expected_beats [$];
  deframed_t  exp_b;
  logic       calm = 1'b0;
  int         in_gap = 0, stall_left = 0;
  int         errors = 0, beats_checked = 0, bytes_sent = 0, frames_sent = 0;
  int         settings = 0;

  function automatic logic [7:0] key_at(input int idx);
    logic [159:0] k;
    k = {key_hi, key_md, key_lo};
    return k[idx*8 +: 8];
  endfunction

  function automatic logic opcode_kept(input logic [15:0] op);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 15; i++) if (kept_list[i] == op) hit = 1'b1;
    return hit;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic decipher_byte(input logic [7:0] b);
    deframed_t   e;
    logic [7:0]  diff;
    logic [7:0]  plain;
    logic [15:0] raw;
    e = '0;
    e.kind = KIND_HEADER;
    if (halted) begin
      e.kind = KIND_DROP;
      e.opcode = cur_opcode;
      e.length = cur_length;
    end else if (payload_left != 0) begin
      e.data = b;
      e.kind = KIND_PAYLOAD;
      payload_left = payload_left - 16'd1;
      e.frame_end = (payload_left == 0);
      e.opcode = cur_opcode;
      e.length = cur_length;
      e.keep = opcode_kept(cur_opcode);
    end else begin
      diff = b - last_cipher;
      plain = diff ^ key_at(hdr_ki);
      hdr_ki = (hdr_ki == KEY_BYTES - 1) ? 0 : hdr_ki + 1;
      last_cipher = b;
      e.data = plain;
      if (hdr_count < 3) begin
        hdr_plain[hdr_count*8 +: 8] = plain;
        hdr_count++;
      end else begin
        // size is big-endian in bytes 0..1, opcode little-endian in 2..3
        raw = {hdr_plain[7:0], hdr_plain[15:8]};
        cur_opcode = {plain, hdr_plain[23:16]};
        cur_length = raw - 16'd2;
        hdr_count = 0;
        hdr_plain = '0;
        e.opcode = cur_opcode;
        e.length = cur_length;
        if (raw < 16'd2 || cur_length > max_len) begin
          halted = 1'b1;
        end else begin
          payload_left = cur_length;
          e.keep = opcode_kept(cur_opcode);
          e.frame_end = (cur_length == 0);
        end
      end
    end
    e.overflow = halted;
    expected_beats.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) decipher_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (rx_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= rx_bytes.pop_front();
          in_gap = calm ? 0 : draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected", out_tdata[15:0], 16'd0);
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_tdata[7:0] !== exp_b.data)
            report_mismatch("out_byte", 16'(out_tdata[7:0]), 16'(exp_b.data));
          if (out_tuser !== exp_b.kind)
            report_mismatch("byte_kind", 16'(out_tuser), 16'(exp_b.kind));
          if (out_tdata[23:8] !== exp_b.opcode)
            report_mismatch("frame_opcode", out_tdata[23:8], exp_b.opcode);
          if (out_tdata[39:24] !== exp_b.length)
            report_mismatch("frame_length", out_tdata[39:24], exp_b.length);
          if (out_tlast !== exp_b.frame_end)
            report_mismatch("frame_end", 16'(out_tlast), 16'(exp_b.frame_end));
          if (out_tdata[40] !== exp_b.keep)
            report_mismatch("keep", 16'(out_tdata[40]), 16'(exp_b.keep));
          if (out_tdata[41] !== exp_b.overflow)
            report_mismatch("overflow", 16'(out_tdata[41]), 16'(exp_b.overflow));
          if (out_tdata[47:42] !== 6'd0)
            report_mismatch("tdata padding", 16'(out_tdata[47:42]), 16'd0);
        end
        beats_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_KEY_LOW:     key_lo = val;
      REG_KEY_MID:     key_md = val;
      REG_KEY_HIGH:    key_hi = val[31:0];
      REG_MAX_PAYLOAD: max_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (rx_bytes.size() != 0 || in_tvalid || expected_beats.size() != 0);
  endtask

  // enciphers four plain header bytes with the running chain
  task automatic send_header(input logic [15:0] raw, input logic [15:0] op);
    logic [31:0] plain;
    logic [7:0]  c;
    plain = {op[15:8], op[7:0], raw[7:0], raw[15:8]};
    for (int i = 0; i < 4; i++) begin
      c = (plain[i*8 +: 8] ^ key_at(enc_ki)) + enc_lc;
      enc_lc = c;
      enc_ki = (enc_ki == KEY_BYTES - 1) ? 0 : enc_ki + 1;
      rx_bytes.push_back(c);
    end
    bytes_sent += 4;
    frames_sent++;
  endtask

  task automatic send_frame(input logic [15:0] size, input logic [15:0] op);
    send_header(size + 16'd2, op);
    for (int i = 0; i < size; i++) rx_bytes.push_back(8'($urandom));
    bytes_sent += size;
  endtask

  function automatic logic [15:0] pick_size();
    int cap, r;
    cap = (max_len < 16) ? max_len : 16;
    r = $urandom_range(0, 49);
    if (r == 0) return 16'($urandom_range(0, (max_len < 300) ? max_len : 300));
    if (r < 8 && max_len <= 80) return max_len;
    if (r < 14) return 16'd0;
    return 16'($urandom_range(0, cap));
  endfunction

  function automatic logic [15:0] pick_opcode();
    int r;
    logic [15:0] op;
    r = $urandom_range(0, 99);
    op = 16'($urandom);
    if (r < 70) op = kept_list[$urandom_range(0, 14)];
    else if (r < 80) op = kept_list[$urandom_range(0, 14)] + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
    return op;
  endfunction

  task automatic run_frames(input int n);
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send_frame(pick_size(), pick_opcode());
    wait_idle();
  endtask

  task automatic new_setting();
    int pick;
    pick = $urandom_range(0, 5);
    if ($urandom_range(0, 1)) write_reg(REG_KEY_LOW, {$urandom, $urandom});
    if ($urandom_range(0, 1)) write_reg(REG_KEY_MID, {$urandom, $urandom});
    if ($urandom_range(0, 1)) write_reg(REG_KEY_HIGH, {32'd0, $urandom});
    case (pick)
      0: write_reg(REG_MAX_PAYLOAD, 64'd0);
      1: write_reg(REG_MAX_PAYLOAD, 64'd65535);
      2: write_reg(REG_MAX_PAYLOAD, 64'd4096);
      3: write_reg(REG_MAX_PAYLOAD, 64'($urandom_range(1, 8)));
      default: write_reg(REG_MAX_PAYLOAD, 64'($urandom_range(9, 80)));
    endcase
    settings++;
  endtask

  initial begin
    int bad;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero key, default limit; empty, one, two and three byte payloads
    send_header(16'd2, 16'h003B);
    send_header(16'd3, 16'hFFFF);
    rx_bytes.push_back(8'hFF);
    send_header(16'd4, 16'h0000);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    send_header(16'd5, 16'h03F1);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'h80);
    rx_bytes.push_back(8'h7F);
    bytes_sent += 6;
    wait_idle();

    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_MID, '1);
    write_reg(REG_KEY_HIGH, 64'hFFFF_FFFF);
    write_reg(REG_MAX_PAYLOAD, 64'd65535);
    settings++;
    run_frames(30);

    // limit of zero: only empty frames are legal
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    write_reg(REG_MAX_PAYLOAD, 64'd0);
    settings++;
    run_frames(15);

    while (bytes_sent < 1350) begin
      new_setting();
      run_frames($urandom_range(8, 30));
    end

    // closing phase: a bad size halts the stream, the rest is dropped
    write_reg(REG_MAX_PAYLOAD, 64'($urandom_range(0, 40)));
    settings++;
    run_frames(4);
    bad = $urandom_range(0, 2);
    case (bad)
      0: send_header(16'd0, pick_opcode());
      1: send_header(16'd1, pick_opcode());
      default: send_header(max_len + 16'd3, pick_opcode());
    endcase
    repeat (20) rx_bytes.push_back(8'($urandom));
    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch("beats never delivered", 16'(expected_beats.size()), 16'd0);

    $display("%0d bytes in %0d frames under %0d register settings, %0d beats checked",
             bytes_sent, frames_sent, settings, beats_checked);
    $display("stream halted by %s", (bad == 2) ? "size above limit" : "size field below 2");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
